// File: hdl/lz_halfword_decompress_assert.svh
// Assertion macros used by the decompressor engine RTL.
`ifndef LZ_HALFWORD_DECOMPRESS_ASSERT_SVH
`define LZ_HALFWORD_DECOMPRESS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LZHD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzhd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LZHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzhd assertion failed");

`endif

// File: hdl/lzhd_pkg.sv
// Types and constants of the halfword LZ decompressor.
`default_nettype none
package lzhd_pkg;

   localparam int HW_W    = 16;
   localparam int TOTAL_W = 24;
   localparam int FLAG_W  = 32;
   localparam int DIST_W  = 11;
   localparam int LEFT_W  = 6;

   localparam logic [FLAG_W-1:0] MARKER_BIT = 32'h0000_8000;
   localparam logic [FLAG_W-1:0] TOP_BIT    = 32'h8000_0000;
   localparam logic [4:0]        LEN_MASK   = 5'h1f;
   localparam int                DIST_SHIFT = 5;
   localparam logic [LEFT_W-1:0] LEN_BIAS   = 6'd2;
   localparam int                CTRL_SHIFT = 16;

   typedef enum logic {
      CMD_DATA  = 1'b0,
      CMD_START = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY
   } state_type;

   typedef enum logic [1:0] {
      SRC_DIRECT,
      SRC_MEM,
      SRC_FWD
   } src_type;

   typedef struct packed {
      logic [HW_W-1:0]    data;
      logic               last_of_run;
      logic               stream_end;
      logic [TOTAL_W-1:0] total_halfwords;
   } elem_type;

endpackage
`default_nettype wire

// File: hdl/lzhd_ring.sv
// History ring memory: one write port, one registered read port.
`default_nettype none
module lzhd_ring #(
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [lzhd_pkg::HW_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [lzhd_pkg::HW_W-1:0] rd_data
);

   logic [lzhd_pkg::HW_W-1:0] mem [DEPTH];
   logic [lzhd_pkg::HW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/lzhd_engine.sv
// Stream decoder, copy sequencer, ring clear and read stage with forwarding.
`default_nettype none
`include "lz_halfword_decompress_assert.svh"
module lzhd_engine #(
   parameter int HISTORY_DEPTH = 2048,
   parameter int COUNT_WIDTH   = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_cmd,
   input  wire logic [lzhd_pkg::HW_W-1:0] req_halfword,
   output logic                           req_stall,
   output logic                           elem_valid,
   input  wire logic                      elem_ready,
   output lzhd_pkg::elem_type             elem
);

   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W+1)'(HISTORY_DEPTH);

   lzhd_pkg::state_type               state_ff, state_in;
   logic [lzhd_pkg::FLAG_W-1:0]       flag_ff, flag_in;
   logic                              ended_ff, ended_in;
   logic [PTR_W-1:0]                  wp_ff, wp_in;
   logic [PTR_W-1:0]                  rp_ff, rp_in;
   logic [PTR_W-1:0]                  clr_ff, clr_in;
   logic [lzhd_pkg::LEFT_W-1:0]       left_ff, left_in;
   logic [COUNT_WIDTH-1:0]            count_ff, count_in;
   logic                              s1_v_ff, s1_v_in;
   lzhd_pkg::src_type                 s1_src_ff, s1_src_in;
   logic                              s1_last_ff, s1_last_in;
   logic                              s1_end_ff, s1_end_in;
   logic [lzhd_pkg::HW_W-1:0]         s1_dat_ff, s1_dat_in;
   logic [lzhd_pkg::HW_W-1:0]         last_wr_ff, last_wr_in;

   logic                              accept;
   logic                              s1_free;
   logic                              s1_move;
   logic                              push;
   logic [lzhd_pkg::HW_W-1:0]         s1_val;
   logic [COUNT_WIDTH-1:0]            cnt_inc;
   logic [lzhd_pkg::FLAG_W-1:0]       flag_adv;
   logic [lzhd_pkg::DIST_W-1:0]       back_dist;
   logic [PTR_W:0]                    diff;
   logic                              wr_en;
   logic [PTR_W-1:0]                  wr_addr;
   logic [lzhd_pkg::HW_W-1:0]         wr_data;
   logic                              rd_en;
   logic [lzhd_pkg::HW_W-1:0]         rd_data;

   lzhd_ring #(
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzhd_pkg::ST_CLEAR;
         flag_ff  <= '0;
         ended_ff <= 1'b0;
         wp_ff    <= '0;
         clr_ff   <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         s1_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         flag_ff  <= flag_in;
         ended_ff <= ended_in;
         wp_ff    <= wp_in;
         clr_ff   <= clr_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         s1_v_ff  <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff      <= rp_in;
      s1_src_ff  <= s1_src_in;
      s1_last_ff <= s1_last_in;
      s1_end_ff  <= s1_end_in;
      s1_dat_ff  <= s1_dat_in;
      last_wr_ff <= last_wr_in;
   end

   always_comb begin
      state_in   = state_ff;
      flag_in    = flag_ff;
      ended_in   = ended_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      clr_in     = clr_ff;
      left_in    = left_ff;
      count_in   = count_ff;
      s1_v_in    = s1_v_ff;
      s1_src_in  = s1_src_ff;
      s1_last_in = s1_last_ff;
      s1_end_in  = s1_end_ff;
      s1_dat_in  = s1_dat_ff;
      last_wr_in = last_wr_ff;
      rd_en      = 1'b0;

      s1_free = !s1_v_ff || elem_ready;
      s1_move = s1_v_ff && elem_ready;
      push    = s1_move && !s1_end_ff;

      unique case (s1_src_ff)
         lzhd_pkg::SRC_MEM: s1_val = rd_data;
         lzhd_pkg::SRC_FWD: s1_val = last_wr_ff;
         default:           s1_val = s1_dat_ff;
      endcase

      cnt_inc = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);

      elem_valid           = s1_v_ff;
      elem.data            = s1_end_ff ? '0 : s1_val;
      elem.last_of_run     = s1_last_ff;
      elem.stream_end      = s1_end_ff;
      elem.total_halfwords = s1_end_ff ? lzhd_pkg::TOTAL_W'(count_ff)
                                       : lzhd_pkg::TOTAL_W'(cnt_inc);

      if (state_ff == lzhd_pkg::ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = push;
         wr_addr = wp_ff;
         wr_data = s1_val;
      end

      if (s1_move) begin
         s1_v_in = 1'b0;
      end
      if (push) begin
         wp_in      = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
         count_in   = cnt_inc;
         last_wr_in = s1_val;
      end

      req_stall = !((state_ff == lzhd_pkg::ST_IDLE) && s1_free);
      accept    = req_valid && !req_stall;

      flag_adv = flag_ff << 1;
      if (flag_adv == lzhd_pkg::TOP_BIT) begin
         flag_adv = '0;
      end
      back_dist = lzhd_pkg::DIST_W'(req_halfword >> lzhd_pkg::DIST_SHIFT);
      diff = (PTR_W+1)'(wp_in) - (PTR_W+1)'(back_dist);
      if (diff[PTR_W]) begin
         diff = diff + DEPTH_EXT;
      end

      unique case (state_ff)
         lzhd_pkg::ST_CLEAR: begin
            clr_in = clr_ff + PTR_W'(1);
            if (clr_ff == PTR_LAST) begin
               state_in = lzhd_pkg::ST_IDLE;
            end
         end
         lzhd_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (req_cmd == lzhd_pkg::CMD_START) begin
                  flag_in  = '0;
                  count_in = '0;
                  ended_in = 1'b0;
               end else if (ended_ff) begin
                  ended_in = 1'b1;
               end else if (flag_ff == '0) begin
                  flag_in = (lzhd_pkg::FLAG_W'(req_halfword) << lzhd_pkg::CTRL_SHIFT)
                            | lzhd_pkg::MARKER_BIT;
               end else if (!flag_ff[lzhd_pkg::FLAG_W-1]) begin
                  flag_in    = flag_adv;
                  s1_v_in    = 1'b1;
                  s1_src_in  = lzhd_pkg::SRC_DIRECT;
                  s1_dat_in  = req_halfword;
                  s1_last_in = 1'b1;
                  s1_end_in  = 1'b0;
               end else if (req_halfword == '0) begin
                  flag_in    = '0;
                  ended_in   = 1'b1;
                  s1_v_in    = 1'b1;
                  s1_src_in  = lzhd_pkg::SRC_DIRECT;
                  s1_dat_in  = '0;
                  s1_last_in = 1'b1;
                  s1_end_in  = 1'b1;
               end else begin
                  flag_in  = flag_adv;
                  left_in  = {1'b0, req_halfword[4:0] & lzhd_pkg::LEN_MASK}
                             + lzhd_pkg::LEN_BIAS;
                  rp_in    = diff[PTR_W-1:0];
                  state_in = lzhd_pkg::ST_COPY;
               end
            end
         end
         lzhd_pkg::ST_COPY: begin
            if (s1_free) begin
               rd_en      = 1'b1;
               s1_v_in    = 1'b1;
               s1_src_in  = (push && (rp_ff == wp_ff)) ? lzhd_pkg::SRC_FWD
                                                       : lzhd_pkg::SRC_MEM;
               s1_last_in = (left_ff == lzhd_pkg::LEFT_W'(1));
               s1_end_in  = 1'b0;
               rp_in      = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);
               left_in    = left_ff - lzhd_pkg::LEFT_W'(1);
               if (left_ff == lzhd_pkg::LEFT_W'(1)) begin
                  state_in = lzhd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lzhd_pkg::ST_IDLE;
         end
      endcase
   end

   `LZHD_ASSERT_NOW(a_no_accept_in_clear, clock, reset,
      state_ff == lzhd_pkg::ST_CLEAR, req_stall && !s1_v_ff)
   `LZHD_ASSERT_NOW(a_left_matches_state, clock, reset,
      1'b1, (state_ff == lzhd_pkg::ST_COPY) == (left_ff != '0))
   `LZHD_ASSERT_NEXT(a_read_fills_stage, clock, reset,
      rd_en, s1_v_ff && (s1_src_ff != lzhd_pkg::SRC_DIRECT))
   `LZHD_ASSERT_NEXT(a_same_slot_forwarded, clock, reset,
      rd_en && wr_en && (rp_ff == wr_addr), s1_src_ff == lzhd_pkg::SRC_FWD)

endmodule
`default_nettype wire

// File: hdl/lz_halfword_decompress.sv
// Top level of the halfword LZ decompressor: engine plus result register.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_cmd, req_halfword
//   rsp      out        rsp_valid / rsp_stall   rsp_data, rsp_last_of_run,
//                                                rsp_stream_end, rsp_total_halfwords
//
// A control word, new-stream command or ignored input yields no result; a literal or
// end token is registered in the read stage and then in the result register.
// A copy of n halfwords (n = 2..33) uses the single ring read port, which delivers
// one halfword per cycle while the read stage is not stalled, forwarded when it is the slot just written.
// After reset the ring is zeroed slot by slot with req_stall high.
// rsp_stall holds the result register and the read stage; the engine then stalls.
`default_nettype none
module lz_halfword_decompress #(
   parameter int HISTORY_DEPTH = 2048,
   parameter int COUNT_WIDTH   = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_cmd,
   input  wire logic [lzhd_pkg::HW_W-1:0]    req_halfword,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [lzhd_pkg::HW_W-1:0]    rsp_data,
   output logic                              rsp_last_of_run,
   output logic                              rsp_stream_end,
   output logic      [lzhd_pkg::TOTAL_W-1:0] rsp_total_halfwords
);

   logic               elem_valid;
   logic               elem_ready;
   lzhd_pkg::elem_type elem;
   logic               rsp_valid_ff, rsp_valid_in;
   lzhd_pkg::elem_type rsp_ff, rsp_in;

   lzhd_engine #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_cmd      (req_cmd),
      .req_halfword (req_halfword),
      .req_stall    (req_stall),
      .elem_valid   (elem_valid),
      .elem_ready   (elem_ready),
      .elem         (elem)
   );

   always_comb begin
      elem_ready   = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (elem_ready) begin
         rsp_valid_in = elem_valid;
         rsp_in       = elem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_ff.data;
   assign rsp_last_of_run     = rsp_ff.last_of_run;
   assign rsp_stream_end      = rsp_ff.stream_end;
   assign rsp_total_halfwords = rsp_ff.total_halfwords;

endmodule
`default_nettype wire

// File: test/lz_halfword_decompress_tb.sv
// Testbench for the halfword LZ decompressor: directed, random and ring-wrap streams.
module lz_halfword_decompress_tb;

   localparam int HW_W           = lzhd_pkg::HW_W;
   localparam int TOTAL_W        = lzhd_pkg::TOTAL_W;
   localparam int FLAG_W         = lzhd_pkg::FLAG_W;
   localparam int DIST_W         = lzhd_pkg::DIST_W;
   localparam int RING_DEPTH     = 2048;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_cmd;
   logic [HW_W-1:0]     req_halfword;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [HW_W-1:0]     rsp_data;
   logic                rsp_last_of_run;
   logic                rsp_stream_end;
   logic [TOTAL_W-1:0]  rsp_total_halfwords;

   lz_halfword_decompress u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_halfword        (req_halfword),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data            (rsp_data),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_stream_end      (rsp_stream_end),
      .rsp_total_halfwords (rsp_total_halfwords)
   );

   // decoder shadow state
   logic [FLAG_W-1:0]  flag_bits;
   logic [HW_W-1:0]    history [RING_DEPTH];
   logic [DIST_W-1:0]  wr_ptr;
   logic [TOTAL_W-1:0] emitted;
   logic               stream_done;

   lzhd_pkg::elem_type pending_words[$];

   int  errors;
   int  decoded_items;
   int  result_count;
   int  copy_count;
   int  end_count;
   int  idle_cycles;
   bit  send_quiet;
   bit  recv_quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void shift_flags();
      flag_bits = flag_bits << 1;
      if (flag_bits == lzhd_pkg::TOP_BIT) flag_bits = '0;
   endfunction

   function automatic void queue_word(logic [HW_W-1:0] d, logic last, logic fin);
      lzhd_pkg::elem_type w;
      w.data            = d;
      w.last_of_run     = last;
      w.stream_end      = fin;
      w.total_halfwords = emitted;
      pending_words.push_back(w);
   endfunction

   function automatic void emit_word(logic [HW_W-1:0] d, logic last);
      history[wr_ptr] = d;
      wr_ptr = wr_ptr + 1'b1;
      if (emitted != '1) emitted = emitted + 1'b1;
      queue_word(d, last, 1'b0);
   endfunction

   function automatic void decode_halfword(lzhd_pkg::cmd_type cmd, logic [HW_W-1:0] hw);
      logic [DIST_W-1:0] back_dist;
      logic [DIST_W-1:0] rd;
      int                len;
      if (cmd == lzhd_pkg::CMD_START) begin
         flag_bits   = '0;
         emitted     = '0;
         stream_done = 1'b0;
         decoded_items++;
      end else if (!stream_done) begin
         decoded_items++;
         if (flag_bits == '0) begin
            flag_bits = (FLAG_W'(hw) << lzhd_pkg::CTRL_SHIFT) | lzhd_pkg::MARKER_BIT;
         end else if ((flag_bits & lzhd_pkg::TOP_BIT) == '0) begin
            shift_flags();
            emit_word(hw, 1'b1);
         end else begin
            shift_flags();
            if (hw == '0) begin
               stream_done = 1'b1;
               flag_bits   = '0;
               end_count++;
               queue_word('0, 1'b1, 1'b1);
            end else begin
               copy_count++;
               back_dist = DIST_W'(hw >> lzhd_pkg::DIST_SHIFT);
               len  = int'(hw[4:0] & lzhd_pkg::LEN_MASK) + int'(lzhd_pkg::LEN_BIAS);
               for (int i = 0; i < len; i++) begin
                  rd = wr_ptr - back_dist;
                  emit_word(history[rd], i == len - 1);
               end
            end
         end
      end
   endfunction

   task automatic send_item(input lzhd_pkg::cmd_type cmd, input logic [HW_W-1:0] hw);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_halfword <= hw;
      do @(posedge clock); while (req_stall);
      decode_halfword(cmd, hw);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   task automatic test_literals();
      send_item(lzhd_pkg::CMD_START, 16'hFFFF);
      send_item(lzhd_pkg::CMD_DATA, 16'h0000);
      send_item(lzhd_pkg::CMD_DATA, 16'hFFFF);
      send_item(lzhd_pkg::CMD_DATA, 16'h0000);
      send_item(lzhd_pkg::CMD_DATA, 16'h8001);
      send_item(lzhd_pkg::CMD_START, 16'h0000);
      wait_drained();
   endtask

   task automatic test_copies();
      send_item(lzhd_pkg::CMD_DATA, 16'h7FFF);
      send_item(lzhd_pkg::CMD_DATA, 16'h1234);
      send_item(lzhd_pkg::CMD_DATA, 16'h0020);   // distance 1, shortest copy
      send_item(lzhd_pkg::CMD_DATA, 16'h001F);   // distance 0, longest copy
      send_item(lzhd_pkg::CMD_DATA, 16'hFFFF);   // farthest distance, longest copy
      send_item(lzhd_pkg::CMD_DATA, 16'hFFE0);
      send_item(lzhd_pkg::CMD_DATA, 16'h0021);
      send_item(lzhd_pkg::CMD_DATA, 16'h0000);
      send_item(lzhd_pkg::CMD_DATA, 16'hABCD);   // dropped after end
      send_item(lzhd_pkg::CMD_DATA, 16'h0000);
      wait_drained();
   endtask

   task automatic test_stream_end();
      send_item(lzhd_pkg::CMD_START, 16'h5555);
      send_item(lzhd_pkg::CMD_DATA, 16'h8000);
      send_item(lzhd_pkg::CMD_DATA, 16'h0000);   // end with nothing emitted
      send_item(lzhd_pkg::CMD_DATA, 16'hFFFF);
      send_item(lzhd_pkg::CMD_START, 16'hAAAA);
      wait_drained();
   endtask

   task automatic test_random_streams(input int n_items);
      int                target;
      int                half;
      bit                paused;
      logic [HW_W-1:0]   ctrl;
      logic [DIST_W-1:0] d;
      logic [4:0]        n;
      target = decoded_items + n_items;
      half   = decoded_items + n_items / 2;
      paused = 1'b0;
      while (decoded_items < target) begin
         send_quiet = ($urandom_range(0, 3) == 0);
         recv_quiet = ($urandom_range(0, 3) == 0);
         if (!paused && decoded_items >= half) begin
            wait_drained();
            paused = 1'b1;
         end
         if (stream_done || $urandom_range(0, 3) == 0)
            send_item(lzhd_pkg::CMD_START, HW_W'($urandom));
         case ($urandom_range(0, 5))
            0:       ctrl = 16'h0000;
            1:       ctrl = 16'hFFFF;
            default: ctrl = HW_W'($urandom);
         endcase
         send_item(lzhd_pkg::CMD_DATA, ctrl);
         for (int f = HW_W - 1; f >= 0; f--) begin
            if ($urandom_range(0, 39) == 0) begin
               send_item(lzhd_pkg::CMD_START, HW_W'($urandom));
               break;
            end
            if (!ctrl[f]) begin
               send_item(lzhd_pkg::CMD_DATA, HW_W'($urandom));
            end else if ($urandom_range(0, 24) == 0) begin
               send_item(lzhd_pkg::CMD_DATA, 16'h0000);
               repeat ($urandom_range(0, 2))
                  send_item(lzhd_pkg::CMD_DATA, HW_W'($urandom));
               break;
            end else begin
               case ($urandom_range(0, 2))
                  0:       d = DIST_W'($urandom_range(0, 4));
                  1:       d = DIST_W'($urandom_range(0, 64));
                  default: d = DIST_W'($urandom);
               endcase
               n = 5'($urandom);
               if ({d, n} == '0) n = 5'd1;
               send_item(lzhd_pkg::CMD_DATA, {d, n});
            end
         end
      end
      wait_drained();
   endtask

   // enough long copies to wrap the ring, then reads of the oldest slots
   task automatic test_ring_wrap();
      recv_quiet = ($urandom_range(0, 1) == 0);
      send_quiet = 1'b0;
      send_item(lzhd_pkg::CMD_START, 16'h0000);
      send_item(lzhd_pkg::CMD_DATA, 16'h0000);
      repeat (16) send_item(lzhd_pkg::CMD_DATA, HW_W'($urandom));
      repeat (4) begin
         send_item(lzhd_pkg::CMD_DATA, 16'hFFFF);
         repeat (16)
            send_item(lzhd_pkg::CMD_DATA, {DIST_W'($urandom_range(1, 64)), 5'h1F});
      end
      send_item(lzhd_pkg::CMD_DATA, 16'hFFFF);
      send_item(lzhd_pkg::CMD_DATA, 16'h001F);
      send_item(lzhd_pkg::CMD_DATA, 16'hFFFF);
      send_item(lzhd_pkg::CMD_DATA, 16'h0000);
      wait_drained();
   endtask

   // result side: random stall per transaction, in-order compare
   initial begin
      lzhd_pkg::elem_type want;
      int                 hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            result_count++;
            if (pending_words.size() == 0) begin
               $error("unexpected result transaction, data %h", rsp_data);
               errors++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_data !== want.data) begin
                  $error("data: expected %h, got %h", want.data, rsp_data);
                  errors++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b",
                         want.last_of_run, rsp_last_of_run);
                  errors++;
               end
               if (rsp_stream_end !== want.stream_end) begin
                  $error("stream_end: expected %b, got %b",
                         want.stream_end, rsp_stream_end);
                  errors++;
               end
               if (rsp_total_halfwords !== want.total_halfwords) begin
                  $error("total_halfwords: expected %0d, got %0d",
                         want.total_halfwords, rsp_total_halfwords);
                  errors++;
               end
            end
            hold_left = recv_quiet ? 0 : $urandom_range(0, 8);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      errors        = 0;
      decoded_items = 0;
      result_count  = 0;
      copy_count    = 0;
      end_count     = 0;
      send_quiet    = 1'b0;
      recv_quiet    = 1'b0;
      flag_bits     = '0;
      wr_ptr        = '0;
      emitted       = '0;
      stream_done   = 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) history[i] = '0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= lzhd_pkg::CMD_DATA;
      req_halfword <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_literals();
      test_copies();
      test_stream_end();
      test_random_streams(24);
      test_ring_wrap();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Decoded %0d input transactions into %0d results (%0d copies, %0d stream ends),",
               decoded_items, result_count, copy_count, end_count);
      $display("including overlapping copies, distance zero and a full wrap of the ring.");
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
